/* hw/rtl/wlp_pkg.sv */
// Shared types and constants of the sliding-window latency percentile tracker.
`default_nettype none
package wlp_pkg;

  localparam int WINDOW_DEF = 256;
  localparam int VAL_W      = 24;

  // ranks come from ceil(pct*n/100)-1; /100 is a multiply by 2^26/100 rounded up
  localparam int RECIP_100  = 671089;
  localparam int RECIP_SH   = 26;
  localparam int RANK_BIAS  = 99;

  // miss percent: misses * 100 * 256 / count
  localparam int PCT_SCALE  = 25600;
  localparam int QUO_W      = 15;

  // deadline: work * fps > 1000 ms with 8 fraction bits
  localparam int DEADLINE   = 256000;

  localparam logic [6:0] PCT_TAB [3] = '{7'd50, 7'd95, 7'd99};

  // calc step schedule
  localparam logic [3:0] STEP_RD0  = 4'd3;
  localparam logic [3:0] STEP_RD3  = 4'd6;
  localparam logic [3:0] STEP_CAP0 = 4'd4;
  localparam logic [3:0] STEP_CAP1 = 4'd5;
  localparam logic [3:0] STEP_CAP2 = 4'd6;
  localparam logic [3:0] STEP_CAP3 = 4'd7;
  localparam logic [3:0] STEP_LAST = 4'd15;
  localparam logic [3:0] DIV_TOP   = 4'd14;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RING, ST_LOOK, ST_REMOVE, ST_INSERT, ST_CALC, ST_OUT0, ST_OUT1
  } wlp_state_t;

  typedef struct packed {
    logic accept;
    logic ring_go;
    logic rem_go;
    logic ins_go;
    logic calc_go;
    logic calc_en;
    logic series;
  } wlp_cmd_t;

  typedef struct packed {
    logic full;
    logic sort_busy;
    logic calc_done;
  } wlp_stat_t;

  typedef struct packed {
    logic rem_go;
    logic ins_go;
    logic rd_en;
  } wlp_sort_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/wlp_sort.sv */
// Sorted sample store with sequential remove and insert scans.
`default_nettype none
module wlp_sort #(
  parameter int W  = wlp_pkg::WINDOW_DEF,
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wlp_pkg::wlp_sort_cmd_t cmd,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic [CW-1:0]        n,
  input  wire logic [23:0]          v,
  output logic                      busy,
  output logic [23:0]               q
);

  logic [23:0] mem [W];
  logic [23:0] q_r;
  logic        rem_r, rem_nxt, ins_r, ins_nxt;
  logic        found_r, found_nxt, pv_r, pv_nxt, pend0_r, pend0_nxt;
  logic [CW-1:0] n_r, n_nxt, ri_r, ri_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [23:0] v_r, v_nxt;
  logic        re, we, gt, stop;
  logic [AW-1:0] ra, wa;
  logic [23:0] wd;

  always_comb begin
    rem_nxt   = rem_r;
    ins_nxt   = ins_r;
    found_nxt = found_r;
    pv_nxt    = pv_r;
    pend0_nxt = pend0_r;
    n_nxt     = n_r;
    ri_nxt    = ri_r;
    pidx_nxt  = pidx_r;
    v_nxt     = v_r;
    re = cmd.rd_en;
    ra = rd_addr;
    we = 1'b0;
    wa = '0;
    wd = v_r;
    gt = q_r > v_r;
    stop = pv_r && !gt;
    if (rem_r) begin
      if (ri_r < n_r) begin
        re = 1'b1;
        ra = AW'(ri_r);
        pv_nxt = 1'b1;
        pidx_nxt = AW'(ri_r);
        ri_nxt = ri_r + 1'b1;
      end else begin
        pv_nxt = 1'b0;
      end
      if (pv_r) begin
        // close the gap left by the first match
        if (found_r) begin
          we = 1'b1;
          wa = pidx_r - 1'b1;
          wd = q_r;
        end else if (q_r == v_r) begin
          found_nxt = 1'b1;
        end
        if (CW'(pidx_r) == n_r - 1'b1) begin
          rem_nxt = 1'b0;
          pv_nxt = 1'b0;
        end
      end
    end else if (ins_r) begin
      if (pend0_r) begin
        we = 1'b1;
        ins_nxt = 1'b0;
        pend0_nxt = 1'b0;
        pv_nxt = 1'b0;
      end else begin
        if (pv_r) begin
          we = 1'b1;
          wa = pidx_r + 1'b1;
          wd = gt ? q_r : v_r;
          if (!gt) begin
            ins_nxt = 1'b0;
          end else if (pidx_r == '0) begin
            pend0_nxt = 1'b1;
          end
        end else if (ri_r == '0) begin
          // empty store
          we = 1'b1;
          ins_nxt = 1'b0;
        end
        if (!stop && ri_r != '0) begin
          re = 1'b1;
          ra = AW'(ri_r - 1'b1);
          pv_nxt = 1'b1;
          pidx_nxt = AW'(ri_r - 1'b1);
          ri_nxt = ri_r - 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
      end
    end
    if (cmd.rem_go) begin
      rem_nxt = 1'b1;
      ri_nxt = '0;
      found_nxt = 1'b0;
      pv_nxt = 1'b0;
      n_nxt = n;
      v_nxt = v;
    end else if (cmd.ins_go) begin
      ins_nxt = 1'b1;
      ri_nxt = n;
      pv_nxt = 1'b0;
      pend0_nxt = 1'b0;
      n_nxt = n;
      v_nxt = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 1'b0;
      ins_r   <= 1'b0;
      found_r <= 1'b0;
      pv_r    <= 1'b0;
      pend0_r <= 1'b0;
      ri_r    <= '0;
      n_r     <= '0;
    end else begin
      rem_r   <= rem_nxt;
      ins_r   <= ins_nxt;
      found_r <= found_nxt;
      pv_r    <= pv_nxt;
      pend0_r <= pend0_nxt;
      ri_r    <= ri_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    v_r    <= v_nxt;
    if (we) mem[wa] <= wd;
    if (re) q_r <= mem[ra];
  end

  assign busy = rem_r | ins_r;
  assign q = q_r;

endmodule
`default_nettype wire

/* hw/rtl/wlp_ctrl.sv */
// Sequencer for one item: ring update and sort scans (records only), statistics, two result beats.
`default_nettype none
module wlp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire wlp_pkg::wlp_stat_t stat,
  output wlp_pkg::wlp_cmd_t       cmd
);

  wlp_pkg::wlp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= wlp_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      wlp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind) begin
            cmd.calc_go = 1'b1;
            state_nxt = wlp_pkg::ST_CALC;
          end else begin
            state_nxt = wlp_pkg::ST_RING;
          end
        end
      end
      wlp_pkg::ST_RING: begin
        cmd.ring_go = 1'b1;
        state_nxt = wlp_pkg::ST_LOOK;
      end
      wlp_pkg::ST_LOOK: begin
        if (stat.full) begin
          cmd.rem_go = 1'b1;
          state_nxt = wlp_pkg::ST_REMOVE;
        end else begin
          cmd.ins_go = 1'b1;
          state_nxt = wlp_pkg::ST_INSERT;
        end
      end
      wlp_pkg::ST_REMOVE: begin
        if (!stat.sort_busy) begin
          cmd.ins_go = 1'b1;
          state_nxt = wlp_pkg::ST_INSERT;
        end
      end
      wlp_pkg::ST_INSERT: begin
        if (!stat.sort_busy) begin
          cmd.calc_go = 1'b1;
          state_nxt = wlp_pkg::ST_CALC;
        end
      end
      wlp_pkg::ST_CALC: begin
        cmd.calc_en = 1'b1;
        if (stat.calc_done) state_nxt = wlp_pkg::ST_OUT0;
      end
      wlp_pkg::ST_OUT0: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = wlp_pkg::ST_OUT1;
      end
      wlp_pkg::ST_OUT1: begin
        out_valid = 1'b1;
        cmd.series = 1'b1;
        if (out_ready) state_nxt = wlp_pkg::ST_IDLE;
      end
      default: state_nxt = wlp_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/wlp_dp.sv */
// Datapath: sample ring, counters, two sorted stores, rank and percent units.
`default_nettype none
module wlp_dp #(
  parameter int W = wlp_pkg::WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wlp_pkg::wlp_cmd_t cmd,
  output wlp_pkg::wlp_stat_t     stat,
  input  wire logic              in_kind,
  input  wire logic [23:0]       in_frame_time,
  input  wire logic [23:0]       in_work_time,
  input  wire logic [9:0]        in_target_rate,
  input  wire logic [23:0]       in_measured_rate,
  output logic                   out_last_of_run,
  output logic [23:0]            out_newest_value,
  output logic [23:0]            out_median_value,
  output logic [23:0]            out_p95_value,
  output logic [23:0]            out_p99_value,
  output logic [23:0]            out_peak_value,
  output logic [8:0]             out_window_count,
  output logic [31:0]            out_total_count,
  output logic [8:0]             out_miss_count,
  output logic [14:0]            out_miss_percent,
  output logic [9:0]             out_echo_target,
  output logic [23:0]            out_echo_measured
);

  localparam int AW = (W > 1) ? $clog2(W) : 1;
  localparam int CW = $clog2(W + 1);
  localparam int XW = CW + 7;
  localparam int PW = XW + 20;
  localparam int NW = CW + wlp_pkg::QUO_W;

  // ring: {miss, work, frame}
  logic [48:0] ring [W];
  logic [48:0] ring_q_r;
  logic        ring_re, ring_we;
  logic [AW-1:0] ring_ra;

  logic [23:0] f_r, w_r, m_r, kept_m_r;
  logic [9:0]  t_r, kept_t_r;
  logic        miss_r, miss_now;
  logic [AW-1:0] pos_r, pos_nxt, newest_pos;
  logic [CW-1:0] count_r, count_nxt, misses_r, misses_nxt;
  logic [31:0] total_r, total_nxt;
  logic [33:0] wt_prod;

  logic [3:0]  step_r;
  logic [NW-1:0] rem_r, dvs;
  logic [wlp_pkg::QUO_W-1:0] quo_r;
  logic [3:0]  shamt;
  logic [XW-1:0] rank_x;
  logic [PW-1:0] rank_p;
  logic [AW-1:0] rank_now;
  logic [AW-1:0] rank_r [3];

  wlp_pkg::wlp_sort_cmd_t scmd;
  logic [AW-1:0] s_addr;
  logic [23:0] fs_v, ws_v, fs_q, ws_q;
  logic        fs_busy, ws_busy;

  logic [23:0] val_r [2][5];

  assign wt_prod  = 34'(w_r) * 34'(t_r);
  assign miss_now = (t_r != '0) && (wt_prod > 34'(wlp_pkg::DEADLINE));
  assign pos_nxt  = (pos_r == AW'(W - 1)) ? '0 : pos_r + 1'b1;
  assign newest_pos = (pos_r == '0) ? AW'(W - 1) : pos_r - 1'b1;

  // ring port
  always_comb begin
    ring_re = 1'b0;
    ring_we = 1'b0;
    ring_ra = pos_r;
    if (cmd.ring_go) begin
      ring_re = 1'b1;
      ring_we = 1'b1;
    end else if (cmd.calc_en && step_r == wlp_pkg::STEP_RD0) begin
      ring_re = 1'b1;
      ring_ra = newest_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[pos_r] <= {miss_now, w_r, f_r};
    if (ring_re) ring_q_r <= ring[ring_ra];
  end

  // counters
  always_comb begin
    count_nxt  = count_r;
    misses_nxt = misses_r;
    total_nxt  = total_r;
    if (cmd.accept && in_kind) begin
      count_nxt  = '0;
      misses_nxt = '0;
      total_nxt  = '0;
    end else if (cmd.rem_go) begin
      count_nxt  = count_r - 1'b1;
      misses_nxt = misses_r - CW'(ring_q_r[48]);
    end else if (cmd.ins_go) begin
      count_nxt  = count_r + 1'b1;
      misses_nxt = misses_r + CW'(miss_r);
      total_nxt  = total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      misses_r <= '0;
      total_r  <= '0;
      pos_r    <= '0;
      kept_t_r <= '0;
      kept_m_r <= '0;
      step_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      misses_r <= misses_nxt;
      total_r  <= total_nxt;
      if (cmd.accept && in_kind) pos_r <= '0;
      else if (cmd.ins_go) pos_r <= pos_nxt;
      if (cmd.ins_go) begin
        kept_t_r <= t_r;
        kept_m_r <= m_r;
      end
      if (cmd.calc_go) step_r <= '0;
      else if (cmd.calc_en && step_r != wlp_pkg::STEP_LAST) step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      f_r <= in_frame_time;
      w_r <= in_work_time;
      t_r <= in_target_rate;
      m_r <= in_measured_rate;
    end
    if (cmd.ring_go) miss_r <= miss_now;
  end

  // sorted stores
  assign fs_v = cmd.rem_go ? ring_q_r[23:0] : f_r;
  assign ws_v = cmd.rem_go ? ring_q_r[47:24] : w_r;

  always_comb begin
    scmd.rem_go = cmd.rem_go;
    scmd.ins_go = cmd.ins_go;
    scmd.rd_en  = cmd.calc_en && step_r >= wlp_pkg::STEP_RD0 && step_r <= wlp_pkg::STEP_RD3;
    unique case (step_r[1:0])
      2'd3:    s_addr = rank_r[0];
      2'd0:    s_addr = rank_r[1];
      2'd1:    s_addr = rank_r[2];
      default: s_addr = AW'(count_r - 1'b1);
    endcase
  end

  wlp_sort #(.W(W), .AW(AW), .CW(CW)) u_frame_sort (
    .clk(clk), .rst_n(rst_n), .cmd(scmd), .rd_addr(s_addr), .n(count_r),
    .v(fs_v), .busy(fs_busy), .q(fs_q)
  );

  wlp_sort #(.W(W), .AW(AW), .CW(CW)) u_work_sort (
    .clk(clk), .rst_n(rst_n), .cmd(scmd), .rd_addr(s_addr), .n(count_r),
    .v(ws_v), .busy(ws_busy), .q(ws_q)
  );

  // rank = ceil(pct*n/100) - 1
  assign rank_x   = XW'(wlp_pkg::PCT_TAB[step_r[1:0]]) * XW'(count_r)
                    + XW'(wlp_pkg::RANK_BIAS);
  assign rank_p   = PW'(rank_x) * PW'(wlp_pkg::RECIP_100);
  assign rank_now = AW'((rank_p >> wlp_pkg::RECIP_SH) - 1'b1);

  // restoring divider, one quotient bit per step
  assign shamt = wlp_pkg::DIV_TOP - step_r;
  assign dvs   = NW'(count_r) << shamt;

  always_ff @(posedge clk) begin
    if (cmd.calc_go) begin
      rem_r <= NW'(misses_nxt) * NW'(wlp_pkg::PCT_SCALE);
      quo_r <= '0;
    end else if (cmd.calc_en && step_r != wlp_pkg::STEP_LAST) begin
      if (rem_r >= dvs) begin
        rem_r <= rem_r - dvs;
        quo_r[shamt] <= 1'b1;
      end
    end
    if (cmd.calc_en && step_r < wlp_pkg::STEP_RD0) rank_r[step_r[1:0]] <= rank_now;
    if (cmd.calc_en) begin
      unique case (step_r)
        wlp_pkg::STEP_CAP0: begin
          val_r[0][0] <= ring_q_r[23:0];
          val_r[1][0] <= ring_q_r[47:24];
          val_r[0][1] <= fs_q;
          val_r[1][1] <= ws_q;
        end
        wlp_pkg::STEP_CAP1: begin
          val_r[0][2] <= fs_q;
          val_r[1][2] <= ws_q;
        end
        wlp_pkg::STEP_CAP2: begin
          val_r[0][3] <= fs_q;
          val_r[1][3] <= ws_q;
        end
        wlp_pkg::STEP_CAP3: begin
          val_r[0][4] <= fs_q;
          val_r[1][4] <= ws_q;
        end
        default: ;
      endcase
    end
  end

  assign stat.full      = count_r == CW'(W);
  assign stat.sort_busy = fs_busy | ws_busy;
  assign stat.calc_done = step_r == wlp_pkg::STEP_LAST;

  logic empty;
  assign empty = count_r == '0;

  assign out_last_of_run   = cmd.series;
  assign out_newest_value  = empty ? '0 : val_r[cmd.series][0];
  assign out_median_value  = empty ? '0 : val_r[cmd.series][1];
  assign out_p95_value     = empty ? '0 : val_r[cmd.series][2];
  assign out_p99_value     = empty ? '0 : val_r[cmd.series][3];
  assign out_peak_value    = empty ? '0 : val_r[cmd.series][4];
  assign out_window_count  = 9'(count_r);
  assign out_total_count   = total_r;
  assign out_miss_count    = 9'(misses_r);
  assign out_miss_percent  = empty ? '0 : quo_r;
  assign out_echo_target   = kept_t_r;
  assign out_echo_measured = kept_m_r;

endmodule
`default_nettype wire

/* hw/rtl/window_latency_percentiles.sv */
// Top level of the sliding-window latency percentile tracker.
//
//  channel | dir | fields                                            | handshake
//  in_     | in  | kind, frame/work time, target/measured rate       | in_valid/in_ready
//  out_    | out | last_of_run, newest, p50/p95/p99, peak, counts... | out_valid/out_ready
//
// One item at a time. A clear passes through the accepting cycle and the statistics
// step before the two result beats.
// A record with room passes through the ring update, the insert scan and the statistics
// step before its first result beat; a full window adds the removal scan of the oldest
// sample. The sorted stores are memories with one read and one write port, scanned
// one entry a cycle. The statistics step holds the serial divider.
// Synchronous active-low reset empties the window; store contents stay undefined.
// in_ready is low from acceptance until the second result beat is taken;
// a stalled result beat holds its fields.
`default_nettype none
module window_latency_percentiles #(
  parameter int WINDOW = wlp_pkg::WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [23:0] in_frame_time,
  input  wire logic [23:0] in_work_time,
  input  wire logic [9:0]  in_target_rate,
  input  wire logic [23:0] in_measured_rate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_last_of_run,
  output logic [23:0]      out_newest_value,
  output logic [23:0]      out_median_value,
  output logic [23:0]      out_p95_value,
  output logic [23:0]      out_p99_value,
  output logic [23:0]      out_peak_value,
  output logic [8:0]       out_window_count,
  output logic [31:0]      out_total_count,
  output logic [8:0]       out_miss_count,
  output logic [14:0]      out_miss_percent,
  output logic [9:0]       out_echo_target,
  output logic [23:0]      out_echo_measured
);

  wlp_pkg::wlp_cmd_t  cmd;
  wlp_pkg::wlp_stat_t stat;

  wlp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_kind(in_kind),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  wlp_dp #(.W(WINDOW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_kind(in_kind), .in_frame_time(in_frame_time), .in_work_time(in_work_time),
    .in_target_rate(in_target_rate), .in_measured_rate(in_measured_rate),
    .out_last_of_run(out_last_of_run), .out_newest_value(out_newest_value),
    .out_median_value(out_median_value), .out_p95_value(out_p95_value),
    .out_p99_value(out_p99_value), .out_peak_value(out_peak_value),
    .out_window_count(out_window_count), .out_total_count(out_total_count),
    .out_miss_count(out_miss_count), .out_miss_percent(out_miss_percent),
    .out_echo_target(out_echo_target), .out_echo_measured(out_echo_measured)
  );

endmodule
`default_nettype wire

/* hw/rtl/wlp_check.sv */
// Port-level checks for the tracker, bound to the top level.
`default_nettype none
module wlp_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_last_of_run,
  input wire logic [23:0] out_newest_value,
  input wire logic [23:0] out_median_value,
  input wire logic [8:0]  out_window_count,
  input wire logic [8:0]  out_miss_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_newest_value)
      && $stable(out_last_of_run))
    else $error("stalled result beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_last_of_run)
    else $error("work beat does not follow frame beat");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready for input while results pending");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_count == 9'd0 |-> out_median_value == 24'd0
      && out_miss_count == 9'd0)
    else $error("empty window gave nonzero statistics");

endmodule

bind window_latency_percentiles wlp_check u_wlp_check (.*);
`default_nettype wire
